// ===== design/mwc_uniform_generator_bank_top_assert.svh =====
// Assertion macros for the multiply-with-carry generator bank.
`ifndef MWC_UNIFORM_GENERATOR_BANK_TOP_ASSERT_SVH
`define MWC_UNIFORM_GENERATOR_BANK_TOP_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MWCU_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MWCU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mwcu_pkg.sv =====
// Shared types, constants and arithmetic helpers of the generator bank.
package mwcu_pkg;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 7;
    localparam int M_TDATA_W = 96;

    localparam logic [15:0] MULT_LO = 16'd36969;
    localparam logic [15:0] MULT_HI = 16'd18000;

    localparam logic [31:0] BAD_MOD_LO   = 32'h9068_FFFF;
    localparam logic [31:0] BAD_MOD_HI   = 32'h464F_FFFF;
    localparam logic [31:0] BAD_MOD_HI_2 = 32'h8C9F_FFFE;
    localparam logic [31:0] BAD_MOD_HI_3 = 32'hD2EF_FFFD;

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef struct packed {
        logic capture;
        logic red_raw;
        logic red_inv;
        logic advance;
        logic commit;
    } mwcu_cmd_t;

    typedef struct packed {
        logic op_load;
        logic sel_valid;
    } mwcu_status_t;

    // The low modulus exceeds half the 32-bit range, so one subtraction suffices.
    function automatic logic [31:0] mod_lo(input logic [31:0] x);
        logic [31:0] r;
        r = (x >= BAD_MOD_LO) ? (x - BAD_MOD_LO) : x;
        return r;
    endfunction

    // The high modulus fits at most three times into a 32-bit word.
    function automatic logic [31:0] mod_hi(input logic [31:0] x);
        logic [31:0] r;
        if (x >= BAD_MOD_HI_3) begin
            r = x - BAD_MOD_HI_3;
        end else if (x >= BAD_MOD_HI_2) begin
            r = x - BAD_MOD_HI_2;
        end else if (x >= BAD_MOD_HI) begin
            r = x - BAD_MOD_HI;
        end else begin
            r = x;
        end
        return r;
    endfunction

    function automatic logic [31:0] mwc_advance(input logic [31:0] half,
                                                input logic [15:0] mult);
        logic [31:0] prod;
        prod = {16'd0, mult} * {16'd0, half[15:0]};
        return prod + {16'd0, half[31:16]};
    endfunction

endpackage

// ===== design/mwcu_ctrl.sv =====
// Controller state machine that sequences draws and seed loads.
module mwcu_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    input  mwcu_pkg::mwcu_status_t  status,
    output mwcu_pkg::mwcu_cmd_t     cmd
);
    import mwcu_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RED_RAW,
        ST_RED_INV,
        ST_ADVANCE,
        ST_COMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd.capture = (state_reg == ST_IDLE) && s_tvalid;
        cmd.red_raw = (state_reg == ST_RED_RAW);
        cmd.red_inv = (state_reg == ST_RED_INV);
        cmd.advance = (state_reg == ST_ADVANCE);
        cmd.commit  = (state_reg == ST_COMMIT) && out_free;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!status.sel_valid) begin
                    state_next = ST_COMMIT;
                end else if (status.op_load) begin
                    state_next = ST_RED_RAW;
                end else begin
                    state_next = ST_ADVANCE;
                end
            end
            ST_RED_RAW: state_next = ST_RED_INV;
            ST_RED_INV: state_next = ST_COMMIT;
            ST_ADVANCE: state_next = ST_COMMIT;
            ST_COMMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.commit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ===== design/mwcu_datapath.sv =====
// Datapath with the seed table, master generator, reduction and MWC arithmetic.
module mwcu_datapath #(
    parameter int NUM_GENERATORS = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [mwcu_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [mwcu_pkg::S_TUSER_W-1:0]    s_tuser,
    input  logic                              cfg_valid,
    input  logic                              cfg_data,
    output logic [mwcu_pkg::M_TDATA_W-1:0]    m_tdata,
    input  mwcu_pkg::mwcu_cmd_t               cmd,
    output mwcu_pkg::mwcu_status_t            status
);
    import mwcu_pkg::*;

    localparam int IDX_W = (NUM_GENERATORS > 1) ? $clog2(NUM_GENERATORS) : 1;
    localparam int CMP_W = 13;

    logic [63:0]       mem [NUM_GENERATORS];
    logic [63:0]       rd_data_reg;
    logic [63:0]       master_reg;
    logic              serial_mode_reg;
    logic              op_load_reg;
    logic              sel_valid_reg;
    logic [IDX_W-1:0]  addr_reg;
    logic [63:0]       seed_reg;
    logic [31:0]       lo_reg;
    logic [31:0]       hi_reg;
    logic [31:0]       out_word_reg;
    logic [63:0]       out_seed_reg;

    logic [5:0]        gen_index;
    logic [IDX_W+5:0]  index_ext;
    logic              in_range;
    logic [63:0]       slot;
    logic [63:0]       new_state;
    logic [31:0]       word;

    assign gen_index = s_tuser[6:1];
    assign index_ext = {{IDX_W{1'b0}}, gen_index};
    assign in_range  = (CMP_W'(gen_index) < CMP_W'(NUM_GENERATORS));
    assign slot      = serial_mode_reg ? master_reg : rd_data_reg;
    assign new_state = {hi_reg, lo_reg};
    assign word      = {lo_reg[15:0], lo_reg[31:16]} + hi_reg;

    assign status.op_load   = op_load_reg;
    assign status.sel_valid = sel_valid_reg;
    assign m_tdata          = {out_seed_reg, out_word_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            serial_mode_reg <= 1'b0;
            master_reg      <= 64'd0;
        end else begin
            if (cfg_valid) begin
                serial_mode_reg <= cfg_data;
            end
            if (cmd.commit && sel_valid_reg && serial_mode_reg) begin
                master_reg <= new_state;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[addr_reg];
        if (cmd.commit && sel_valid_reg && !serial_mode_reg) begin
            mem[addr_reg] <= new_state;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_load_reg   <= (s_tuser[0] == OP_LOAD);
            sel_valid_reg <= serial_mode_reg || in_range;
            addr_reg      <= index_ext[IDX_W-1:0];
            seed_reg      <= s_tdata;
        end
        if (cmd.red_raw) begin
            lo_reg <= mod_lo(seed_reg[31:0]);
            hi_reg <= mod_hi(seed_reg[63:32]);
        end
        if (cmd.red_inv) begin
            if (lo_reg == 32'd0) begin
                lo_reg <= mod_lo(~seed_reg[31:0]);
            end
            if (hi_reg == 32'd0) begin
                hi_reg <= mod_hi(~seed_reg[63:32]);
            end
        end
        if (cmd.advance) begin
            lo_reg <= mwc_advance(slot[31:0], MULT_LO);
            hi_reg <= mwc_advance(slot[63:32], MULT_HI);
        end
        if (cmd.commit) begin
            out_word_reg <= (sel_valid_reg && !op_load_reg) ? word : 32'd0;
            out_seed_reg <= sel_valid_reg ? new_state : 64'd0;
        end
    end

endmodule

// ===== design/mwc_uniform_generator_bank_top.sv =====
// Top level of the multiply-with-carry uniform generator bank.
// A draw passes through the decode, advance and commit states, a seed load through decode, both
// reduction states and commit, an index outside the table through decode and commit; one item is in flight at a time.
// The next beat is accepted while a finished result still waits in the output register.
// Reset (synchronous, aresetn low) clears the controller, serial mode and master seed.
// The seed table has no clearing pass; entries hold anything until loaded.
module mwc_uniform_generator_bank_top #(
    parameter int NUM_GENERATORS = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mwcu_pkg::S_TDATA_W-1:0]    s_tdata,  // seed_in[63:0]
    input  logic [mwcu_pkg::S_TUSER_W-1:0]    s_tuser,  // op[0], gen_index[6:1]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mwcu_pkg::M_TDATA_W-1:0]    m_tdata,  // rand_word[31:0], seed_out[95:32]
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data
);
    import mwcu_pkg::*;

    mwcu_cmd_t    cmd;
    mwcu_status_t status;
    logic         cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    mwcu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mwcu_datapath #(
        .NUM_GENERATORS (NUM_GENERATORS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_write),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

`include "mwc_uniform_generator_bank_top_assert.svh"

    `MWCU_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input accepted while an item is in flight")
    `MWCU_ASSERT_SAME(a_commit_output_free, aclk, aresetn, cmd.commit, !m_tvalid || m_tready, "result overwrote a beat not yet taken")
    `MWCU_ASSERT_NEXT(a_load_word_zero, aclk, aresetn, cmd.commit && status.op_load, m_tvalid && (m_tdata[31:0] == 32'd0), "seed load produced a nonzero word")

endmodule

// ===== tb/mwc_uniform_generator_bank_top_tb.sv =====
// Self-checking testbench for the multiply-with-carry uniform generator bank.
`timescale 1ns / 1ps

module mwc_uniform_generator_bank_top_tb;
    import mwcu_pkg::*;

    localparam int NUM_GEN      = 64;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [63:0] seed_out;
        logic [31:0] rand_word;
    } bank_result_t;

    class mwc_bank_scoreboard;
        logic         serial_mode;
        logic [63:0]  serial_seed;
        logic [63:0]  entry_seed [NUM_GEN];
        bank_result_t expected_results [$];
        int           errors;
        int           checked;

        function new();
            serial_mode = 1'b0;
            serial_seed = '0;
            foreach (entry_seed[i]) entry_seed[i] = '0;
            errors  = 0;
            checked = 0;
        endfunction

        function logic [31:0] clean_half(input logic [31:0] half, input logic [31:0] modulus);
            logic [31:0] r;
            r = half % modulus;
            if (r == 32'd0) begin
                r = (~half) % modulus;
            end
            return r;
        endfunction

        function logic [31:0] step_half(input logic [31:0] half, input logic [15:0] mult);
            logic [31:0] r;
            r = {16'd0, mult} * {16'd0, half[15:0]} + {16'd0, half[31:16]};
            return r;
        endfunction

        function void note_beat(input logic op, input logic [5:0] idx, input logic [63:0] seed);
            bank_result_t res;
            logic [63:0]  cur;
            logic [31:0]  lo;
            logic [31:0]  hi;
            res = '0;
            if (!serial_mode && idx >= NUM_GEN) begin
                expected_results.push_back(res);
                return;
            end
            cur = serial_mode ? serial_seed : entry_seed[idx];
            if (op == OP_LOAD) begin
                cur = {clean_half(seed[63:32], BAD_MOD_HI), clean_half(seed[31:0], BAD_MOD_LO)};
            end else begin
                lo  = step_half(cur[31:0], MULT_LO);
                hi  = step_half(cur[63:32], MULT_HI);
                cur = {hi, lo};
                res.rand_word = {lo[15:0], lo[31:16]} + hi;
            end
            if (serial_mode) begin
                serial_seed = cur;
            end else begin
                entry_seed[idx] = cur;
            end
            res.seed_out = cur;
            expected_results.push_back(res);
        endfunction

        function void check_beat(input logic [M_TDATA_W-1:0] data);
            bank_result_t got;
            bank_result_t want;
            got = data;
            if (expected_results.size() == 0) begin
                $error("unexpected result beat: actual %h", data);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            checked++;
            if (got.rand_word !== want.rand_word) begin
                $error("rand_word: expected %h, actual %h", want.rand_word, got.rand_word);
                errors++;
            end
            if (got.seed_out !== want.seed_out) begin
                $error("seed_out: expected %h, actual %h", want.seed_out, got.seed_out);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;  // seed_in[63:0]
    logic [S_TUSER_W-1:0] s_tuser   = '0;  // op[0], gen_index[6:1]
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // rand_word[31:0], seed_out[95:32]
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_data  = 1'b0;

    mwc_bank_scoreboard sb = new();

    int          cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_len       = 0;
    logic        mode_now       = 1'b0;
    logic [63:0] entry_loaded   = '0;
    int          n_draws        = 0;
    int          n_loads        = 0;
    int          n_serial       = 0;

    mwc_uniform_generator_bank_top #(
        .NUM_GENERATORS(NUM_GEN)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // The long hold-off is counted down here while the sender keeps offering beats.
    always @(posedge aclk) begin
        if (hold_len > 0) begin
            m_tready <= 1'b0;
            hold_len = hold_len - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                sb.serial_mode = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                sb.note_beat(s_tuser[0], s_tuser[6:1], s_tdata);
                if (s_tuser[0] == OP_LOAD) n_loads++;
                else n_draws++;
                if (sb.serial_mode) n_serial++;
            end
            if (m_tvalid && m_tready) begin
                sb.check_beat(m_tdata);
            end
        end
    end

    task automatic send_item(input logic op, input logic [5:0] idx, input logic [63:0] seed);
        if (!mode_now && op == OP_LOAD) begin
            entry_loaded[idx] = 1'b1;
        end
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= seed;
        s_tuser  <= {idx, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input logic value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        mode_now = value;
    endtask

    function automatic logic [31:0] pick_half(input logic [31:0] modulus);
        logic [31:0] v;
        case ($urandom_range(9))
            0: v = 32'd0;
            1: v = 32'hFFFF_FFFF;
            2: v = modulus;
            3: v = modulus * $urandom_range(3, 1);
            4: v = ~modulus;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic random_item();
        logic        op;
        logic [5:0]  idx;
        logic [63:0] seed;
        op   = ($urandom_range(99) < 30) ? OP_LOAD : OP_DRAW;
        idx  = $urandom_range(63);
        seed = {pick_half(BAD_MOD_HI), pick_half(BAD_MOD_LO)};
        if (!mode_now) begin
            if (entry_loaded == '0) op = OP_LOAD;
            if (op == OP_DRAW) begin
                while (!entry_loaded[idx]) idx = $urandom_range(63);
            end
        end
        send_item(op, idx, seed);
    endtask

    initial begin
        int ph;
        int k;
        int idle_send [4] = '{0, 50, 0, 29};
        int idle_recv [4] = '{0, 0, 50, 29};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_mode(1'b1);
        send_item(OP_DRAW, 6'd0, {$urandom, $urandom});
        send_item(OP_DRAW, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_LOAD, 6'd0, 64'd0);
        send_item(OP_DRAW, 6'd0, 64'd0);
        send_item(OP_LOAD, 6'd42, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_DRAW, 6'd17, {$urandom, $urandom});
        send_item(OP_LOAD, 6'd63, {BAD_MOD_HI_3, BAD_MOD_LO});
        send_item(OP_DRAW, 6'd63, 64'd0);
        send_item(OP_DRAW, 6'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        drain_results();

        write_mode(1'b0);
        send_item(OP_LOAD, 6'd0, {BAD_MOD_HI, BAD_MOD_LO});
        send_item(OP_LOAD, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_LOAD, 6'd5, {BAD_MOD_HI_2, 32'd0});
        send_item(OP_DRAW, 6'd0, 64'd0);
        send_item(OP_DRAW, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_DRAW, 6'd63, 64'd0);
        send_item(OP_DRAW, 6'd5, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_LOAD, 6'd0, {~BAD_MOD_HI, ~BAD_MOD_LO});
        send_item(OP_DRAW, 6'd0, {$urandom, $urandom});
        drain_results();

        write_mode(1'b1);
        send_item(OP_DRAW, 6'd9, {$urandom, $urandom});
        drain_results();
        write_mode(1'b0);
        send_item(OP_DRAW, 6'd63, {$urandom, $urandom});

        for (ph = 0; ph < 8; ph++) begin
            drain_results();
            send_idle_pct  = idle_send[ph % 4];
            recv_stall_pct = idle_recv[ph % 4];
            write_mode(ph % 2 == 0);
            for (k = 0; k < 80; k++) begin
                if (ph == 2 && k == 10) hold_len = HOLD_CYCLES;
                random_item();
            end
        end
        drain_results();

        $display("Checked %0d result beats from %0d draws and %0d seed loads.",
                 sb.checked, n_draws, n_loads);
        $display("%0d beats used the master generator, the rest the indexed table.",
                 n_serial);
        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+design
design/mwcu_pkg.sv
design/mwcu_ctrl.sv
design/mwcu_datapath.sv
design/mwc_uniform_generator_bank_top.sv
tb/mwc_uniform_generator_bank_top_tb.sv
